@@ hw/rtl/utf8f_pkg.sv @@
package utf8f_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned KEPT_W    = 16;
   localparam int unsigned PEND_DEPTH = 5;
   localparam int unsigned RUN_MAX   = 6;
   localparam int unsigned CNT_W     = 3;

   // One group of result beats caused by a single input beat.
   typedef struct packed {
      logic [RUN_MAX-1:0][BYTE_W-1:0] bytes;
      logic [CNT_W-1:0]               cnt;
      logic                           byte_valid;
      logic                           last;
      logic [KEPT_W-1:0]              kept;
   } run_type;

   // Number of continuation bytes announced by a lead byte; zero if the byte
   // does not open a multi-byte sequence.
   function automatic logic [CNT_W-1:0] lead_conts(input logic [BYTE_W-1:0] b);
      logic [CNT_W-1:0] k;
      k = '0;
      case (b) inside
         8'b110?????: k = 3'd1;
         8'b1110????: k = 3'd2;
         8'b11110???: k = 3'd3;
         8'b111110??: k = 3'd4;
         8'b1111110?: k = 3'd5;
         default:     k = 3'd0;
      endcase
      return k;
   endfunction

endpackage

@@ hw/rtl/utf8f_seq.sv @@
module utf8f_seq #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic [utf8f_pkg::BYTE_W-1:0] in_byte,
   input  logic                      last_byte,
   output logic                      run_load,
   output utf8f_pkg::run_type        run
);
   import utf8f_pkg::*;

   logic [BYTE_W-1:0]     pend_ff [PEND_DEPTH];
   logic [BYTE_W-1:0]     pend_in [PEND_DEPTH];
   logic [CNT_W-1:0]      expect_ff, expect_in;
   logic [CNT_W-1:0]      seen_ff, seen_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;

   logic                  is_cont;
   logic                  complete;
   logic [CNT_W-1:0]      lead_k;
   logic [CNT_W-1:0]      n_kept;
   logic [COUNT_BITS:0]   sum;
   logic [COUNT_BITS-1:0] total_sat;
   logic [KEPT_W-1:0]     kept_rep;

   assign is_cont  = (in_byte[7:6] == 2'b10);
   assign lead_k   = lead_conts(in_byte);
   assign complete = is_cont && (expect_ff != '0) &&
                     (({1'b0, seen_ff} + 4'd1) >= {1'b0, expect_ff});

   always_comb begin
      if (complete) begin
         n_kept = seen_ff + 3'd2;
      end else if (!in_byte[7]) begin
         n_kept = 3'd1;
      end else begin
         n_kept = 3'd0;
      end
   end

   assign sum       = {1'b0, total_ff} + {{(COUNT_BITS+1-CNT_W){1'b0}}, n_kept};
   assign total_sat = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

   generate
      if (COUNT_BITS >= KEPT_W) begin : g_wide
         assign kept_rep = total_sat[KEPT_W-1:0];
      end else begin : g_narrow
         assign kept_rep = {{(KEPT_W-COUNT_BITS){1'b0}}, total_sat};
      end
   endgenerate

   // Next state of the sequence tracker.
   always_comb begin
      for (int i = 0; i < PEND_DEPTH; i++) begin
         pend_in[i] = pend_ff[i];
      end
      expect_in = expect_ff;
      seen_in   = seen_ff;
      if (is_cont) begin
         if (complete) begin
            expect_in = '0;
            seen_in   = '0;
         end else if (expect_ff != '0) begin
            for (int i = 1; i < PEND_DEPTH; i++) begin
               if (3'(i) == seen_ff + 3'd1) begin
                  pend_in[i] = in_byte;
               end
            end
            seen_in = seen_ff + 3'd1;
         end
      end else begin
         // A non-continuation byte always breaks what was pending.
         seen_in   = '0;
         expect_in = lead_k;
         if (lead_k != '0) begin
            pend_in[0] = in_byte;
         end
      end
      if (last_byte) begin
         expect_in = '0;
         seen_in   = '0;
      end
      total_in = last_byte ? '0 : total_sat;
   end

   // Result group for this beat.
   always_comb begin
      run = '0;
      run.last = last_byte;
      run.kept = kept_rep;
      if (complete) begin
         for (int i = 0; i < PEND_DEPTH; i++) begin
            if (3'(i) <= seen_ff) begin
               run.bytes[i] = pend_ff[i];
            end else if (3'(i) == seen_ff + 3'd1) begin
               run.bytes[i] = in_byte;
            end
         end
         if (seen_ff == 3'(PEND_DEPTH - 1)) begin
            run.bytes[RUN_MAX-1] = in_byte;
         end
         run.cnt        = n_kept;
         run.byte_valid = 1'b1;
      end else if (!in_byte[7]) begin
         run.bytes[0]   = in_byte;
         run.cnt        = 3'd1;
         run.byte_valid = 1'b1;
      end else begin
         run.cnt        = 3'd1;
         run.byte_valid = 1'b0;
      end
   end

   assign run_load = take && ((n_kept != '0) || last_byte);

   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < PEND_DEPTH; i++) begin
            pend_ff[i] <= pend_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= '0;
         seen_ff   <= '0;
         total_ff  <= '0;
      end else if (take) begin
         expect_ff <= expect_in;
         seen_ff   <= seen_in;
         total_ff  <= total_in;
      end
   end

endmodule

@@ hw/rtl/utf8f_emit.sv @@
module utf8f_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          run_load,
   input  utf8f_pkg::run_type            run,
   output logic                          load_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [utf8f_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last_of_run,
   output logic                          rsp_end_of_string,
   output logic [utf8f_pkg::KEPT_W-1:0]  rsp_kept_count
);
   import utf8f_pkg::*;

   logic [RUN_MAX-1:0][BYTE_W-1:0] bytes_ff, bytes_in;
   logic [CNT_W-1:0]               remain_ff, remain_in;
   logic                           busy_ff, busy_in;
   logic                           bval_ff, last_ff;
   logic [KEPT_W-1:0]              kept_ff;
   logic                           beat;
   logic                           final_beat;

   assign beat       = busy_ff && rsp_ready;
   assign final_beat = beat && (remain_ff == 3'd1);
   assign load_ready = !busy_ff || final_beat;

   assign rsp_valid         = busy_ff;
   assign rsp_out_byte      = bytes_ff[0];
   assign rsp_byte_valid    = bval_ff;
   assign rsp_last_of_run   = (remain_ff == 3'd1);
   assign rsp_end_of_string = rsp_last_of_run && last_ff;
   assign rsp_kept_count    = rsp_end_of_string ? kept_ff : '0;

   always_comb begin
      bytes_in  = bytes_ff;
      remain_in = remain_ff;
      busy_in   = busy_ff;
      if (run_load) begin
         bytes_in  = run.bytes;
         remain_in = run.cnt;
         busy_in   = 1'b1;
      end else if (final_beat) begin
         busy_in = 1'b0;
      end else if (beat) begin
         bytes_in  = {{BYTE_W{1'b0}}, bytes_ff[RUN_MAX-1:1]};
         remain_in = remain_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff  <= bytes_in;
      remain_ff <= remain_in;
      if (run_load) begin
         bval_ff <= run.byte_valid;
         last_ff <= run.last;
         kept_ff <= run.kept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

@@ hw/rtl/utf8_invalid_byte_filter_unit.sv @@
// A byte that completes a sequence or is plain ASCII shows its first result beat
// in the cycle after it is accepted.
// Throughput: one input beat per cycle while each beat yields at most one result
// and the receiver is ready; a completed sequence holds the input while the
// output register drains it one beat per ready cycle.
// Reset: synchronous, active high; clears the pending sequence, the kept count
// and the busy flag of the output register.
module utf8_invalid_byte_filter_unit #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [utf8f_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                         req_last_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [utf8f_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                         rsp_byte_valid,
   output logic                         rsp_last_of_run,
   output logic                         rsp_end_of_string,
   output logic [utf8f_pkg::KEPT_W-1:0] rsp_kept_count
);
   import utf8f_pkg::*;

   // The design has two parts. The sequence tracker decodes each accepted
   // beat against the pending lead byte and continuations, and in the same
   // cycle forms the group of bytes that the beat releases (possibly none).
   // The emitter registers that group and hands out one beat per ready cycle.

   logic    take;
   logic    run_load;
   logic    load_ready;
   run_type run;

   // A new input beat is taken whenever the emitter is empty or is handing
   // out the final beat of its current group in this very cycle, so single
   // byte results stream at full rate without a bubble.
   assign req_ready = load_ready;
   assign take      = req_valid && load_ready;

   utf8f_seq #(
      .COUNT_BITS(COUNT_BITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .in_byte  (req_in_byte),
      .last_byte(req_last_byte),
      .run_load (run_load),
      .run      (run)
   );

   // The emitter keeps the group in a shift line; the head is always the
   // current result beat, and the end-of-string count shows on the last one.
   utf8f_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .run_load         (run_load),
      .run              (run),
      .load_ready       (load_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_string(rsp_end_of_string),
      .rsp_kept_count   (rsp_kept_count)
   );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

// Testbench for the UTF-8 filter. A directed part walks through plain bytes, stray
// continuations, the two never-valid bytes, sequences of several lengths and the ways a
// sequence can be broken or cut off. Random strings of mostly well-formed characters,
// mixed with truncated sequences and noise, finish the run. Every accepted input beat
// goes through a predictor of the filter. Every result beat is compared against the
// oldest predicted beat.
module tb;
   import utf8f_pkg::*;

   localparam int unsigned      COUNT_W      = 16;
   localparam int unsigned      MAX_GAP      = 12;
   localparam longint unsigned  CYCLE_LIMIT  = 200_000;
   localparam int unsigned      RANDOM_ITEMS = 260;
   localparam int unsigned      BURST_ITEMS  = 70;
   localparam int unsigned      END_WAIT     = 2000;
   localparam logic [KEPT_W-1:0] KEPT_MAX    = '1;
   // The top two bits of a continuation byte.
   localparam logic [1:0]       CONT_TAG     = 2'b10;

   // One result beat as the filter should present it.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              has_byte;
      logic              run_end;
      logic              text_end;
      logic [KEPT_W-1:0] kept;
   } out_beat_type;

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_in_byte   = '0;
   logic                req_last_byte = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_byte_valid;
   logic                rsp_last_of_run;
   logic                rsp_end_of_string;
   logic [KEPT_W-1:0]   rsp_kept_count;

   // Predicted result beats, oldest first.
   out_beat_type        filtered_beats[$];
   // Bytes of the random string being built.
   logic [BYTE_W-1:0]   text_bytes[$];

   // Private copy of the filter state: the held sequence, how many continuations it
   // owes in total, how many have arrived, and the kept count of the current string.
   logic [BYTE_W-1:0]   held_seq[PEND_DEPTH];
   logic [CNT_W-1:0]    conts_owed  = '0;
   logic [CNT_W-1:0]    conts_seen  = '0;
   logic [KEPT_W-1:0]   kept_so_far = '0;

   // When these are clear, the sender and the receiver never idle.
   logic                send_idle = 1'b0;
   logic                recv_idle = 1'b0;

   int unsigned         error_count   = 0;
   int unsigned         bytes_sent    = 0;
   int unsigned         strings_ended = 0;
   int unsigned         beats_checked = 0;
   int unsigned         stall_left    = 0;
   longint unsigned     cycle_count   = 0;

   utf8_invalid_byte_filter_unit #(
      .COUNT_BITS(COUNT_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_kept_count    (rsp_kept_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog. It ends the run as a failure once the cycle limit is reached.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Number of continuations that a lead byte announces. The result is zero for
   // ASCII, continuation bytes, 0xFE and 0xFF.
   function automatic logic [CNT_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
      if (b >= 8'hC0 && b <= 8'hDF) return 3'd1;
      if (b >= 8'hE0 && b <= 8'hEF) return 3'd2;
      if (b >= 8'hF0 && b <= 8'hF7) return 3'd3;
      if (b >= 8'hF8 && b <= 8'hFB) return 3'd4;
      if (b >= 8'hFC && b <= 8'hFD) return 3'd5;
      return 3'd0;
   endfunction

   // Advance the filter state by one accepted byte and queue the result beats it causes.
   task automatic predict_filter(input logic [BYTE_W-1:0] b, input logic last);
      logic [BYTE_W-1:0] run[RUN_MAX];
      logic [CNT_W-1:0]  k;
      out_beat_type      beat;
      int                n;
      int                i;
      n = 0;
      if (b[7:6] == CONT_TAG) begin
         // A continuation byte matters only while a sequence is held. Otherwise it is
         // a stray and is dropped silently.
         if (conts_owed != 0) begin
            if (int'(conts_seen) + 1 >= int'(conts_owed)) begin
               // This byte completes the sequence, so the lead, the held
               // continuations and this byte all go out in order.
               for (i = 0; i <= int'(conts_seen) && i < PEND_DEPTH; i++) begin
                  run[n] = held_seq[i];
                  n++;
               end
               run[n] = b;
               n++;
               conts_owed = '0;
               conts_seen = '0;
            end else begin
               if (int'(conts_seen) + 1 < PEND_DEPTH) held_seq[int'(conts_seen) + 1] = b;
               conts_seen++;
            end
         end
      end else begin
         // Any other byte breaks a held sequence and is then judged on its own.
         conts_owed = '0;
         conts_seen = '0;
         if (!b[7]) begin
            run[n] = b;
            n++;
         end else begin
            k = lead_length(b);
            if (k != 0) begin
               held_seq[0] = b;
               conts_owed  = k;
            end
         end
      end
      for (i = 0; i < n; i++) begin
         if (kept_so_far != KEPT_MAX) kept_so_far++;
      end
      // The end of a string also drops a sequence that has not been completed.
      if (last) begin
         conts_owed = '0;
         conts_seen = '0;
      end
      for (i = 0; i < n; i++) begin
         beat.data     = run[i];
         beat.has_byte = 1'b1;
         beat.run_end  = (i == n - 1);
         beat.text_end = beat.run_end && last;
         beat.kept     = beat.text_end ? kept_so_far : '0;
         filtered_beats.push_back(beat);
      end
      // A final byte that keeps nothing still owes the string a bare end marker.
      if (last && n == 0) begin
         beat.data     = '0;
         beat.has_byte = 1'b0;
         beat.run_end  = 1'b1;
         beat.text_end = 1'b1;
         beat.kept     = kept_so_far;
         filtered_beats.push_back(beat);
      end
      if (last) kept_so_far = '0;
   endtask

   // Present one byte and wait for the handshake. Valid is raised only once per byte.
   // With no gap it simply stays high from the beat before.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      int unsigned gap;
      gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_filter(b, last);
      bytes_sent++;
      if (last) strings_ended++;
   endtask

   // Hold the sender off until every predicted beat has come out. This task is always
   // called right after an accepted beat, so valid drops before a second acceptance.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (filtered_beats.size() != 0);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      end
   endtask

   // Result side. While recv_idle is set, the receiver may drop ready for a random number of cycles
   // after each beat. Each beat it takes is checked against the oldest prediction.
   always @(posedge clock) begin
      out_beat_type want;
      int unsigned  stall;
      if (reset) begin
         rsp_ready  <= 1'b1;
         stall_left = 0;
      end else if (rsp_valid && rsp_ready) begin
         beats_checked++;
         if (filtered_beats.size() == 0) begin
            error_count++;
            $error("result beat with no prediction waiting: out_byte %0h", rsp_out_byte);
         end else begin
            want = filtered_beats.pop_front();
            compare_field("out_byte", 32'(want.data), 32'(rsp_out_byte));
            compare_field("byte_valid", 32'(want.has_byte), 32'(rsp_byte_valid));
            compare_field("last_of_run", 32'(want.run_end), 32'(rsp_last_of_run));
            compare_field("end_of_string", 32'(want.text_end), 32'(rsp_end_of_string));
            compare_field("kept_count", 32'(want.kept), 32'(rsp_kept_count));
         end
         stall = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (stall != 0) begin
            rsp_ready  <= 1'b0;
            stall_left = stall;
         end
      end else if (stall_left != 0) begin
         stall_left--;
         if (stall_left == 0) rsp_ready <= 1'b1;
      end
   end

   // Append one random character to the string being built. Most characters are
   // well formed. The rest are truncated sequences, stray continuations or random bytes.
   task automatic add_char();
      int unsigned       pick;
      int unsigned       len;
      int unsigned       conts;
      logic [BYTE_W-1:0] lead;
      pick = $urandom_range(0, 99);
      len  = $urandom_range(1, 6);
      if (pick >= 70 && pick < 82 && len == 1) len = 2;
      lead = 8'($urandom);
      case (len)
         1: lead = {1'b0, lead[6:0]};
         2: lead = {3'b110, lead[4:0]};
         3: lead = {4'b1110, lead[3:0]};
         4: lead = {5'b11110, lead[2:0]};
         5: lead = {6'b111110, lead[1:0]};
         default: lead = {7'b1111110, lead[0]};
      endcase
      if (pick < 82) begin
         conts = (pick < 70) ? len - 1 : $urandom_range(0, len - 2);
         text_bytes.push_back(lead);
         repeat (conts) text_bytes.push_back({CONT_TAG, 6'($urandom)});
      end else if (pick < 91) begin
         text_bytes.push_back({CONT_TAG, 6'($urandom)});
      end else begin
         text_bytes.push_back(8'($urandom));
      end
   endtask

   // Send the built string with the end flag on its final byte.
   task automatic send_text();
      int i;
      for (i = 0; i < text_bytes.size(); i++)
         send_byte(text_bytes[i], i == text_bytes.size() - 1);
      text_bytes.delete();
   endtask

   // Both ends of ASCII, stray continuations, and the two bytes that never occur in
   // UTF-8. The string ends on a dropped byte, so a bare end marker carries the count.
   task automatic test_single_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hFE, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_for_drain();
   endtask

   // Complete sequences of two, three and six bytes. The last one also ends the string.
   task automatic test_sequences();
      send_byte(8'hC2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hFC, 1'b0);
      repeat (4) send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b1);
      wait_for_drain();
   endtask

   // An ASCII byte breaks a held sequence and is still kept. A 0xFF breaks a held
   // sequence and is then dropped. A string that ends inside a sequence loses that
   // sequence, and only the end marker comes out.
   task automatic test_broken_sequences();
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b1);
      wait_for_drain();
   endtask

   // Random strings with idling on both sides.
   task automatic test_random_strings();
      int unsigned start;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_ITEMS) begin
         repeat ($urandom_range(1, 10)) add_char();
         send_text();
      end
      wait_for_drain();
   endtask

   // Random strings sent back to back, so that beats land on every cycle of a drain.
   task automatic test_back_to_back();
      int unsigned start;
      start = bytes_sent;
      while (bytes_sent - start < BURST_ITEMS) begin
         repeat ($urandom_range(1, 8)) add_char();
         send_text();
      end
      wait_for_drain();
   endtask

   initial begin
      int unsigned w;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_bytes();
      test_sequences();
      test_broken_sequences();

      send_idle = 1'b1;
      recv_idle = 1'b1;
      test_random_strings();

      send_idle = 1'b0;
      recv_idle = 1'b0;
      test_back_to_back();

      // Give any straggling beats time to appear, then keep watching in case the
      // filter sends something extra.
      for (w = 0; w < END_WAIT && filtered_beats.size() != 0; w++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (filtered_beats.size() != 0) begin
         error_count++;
         $error("%0d predicted result beats never arrived", filtered_beats.size());
      end

      $display("Sent %0d bytes in %0d strings and checked %0d result beats.",
               bytes_sent, strings_ended, beats_checked);
      $display("This covered every sequence length, broken and cut-off sequences, ",
               "bare end markers, and traffic with and without idling.");
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/utf8f_pkg.sv
hw/rtl/utf8f_seq.sv
hw/rtl/utf8f_emit.sv
hw/rtl/utf8_invalid_byte_filter_unit.sv
sim/tb.sv
